// File: rtl/esrt_pkg.sv
package esrt_pkg;

	localparam int ANG_STEPS = 30;
	localparam int CORDIC_LAT = ANG_STEPS + 2;
	localparam int XW = 34;
	localparam int QDEPTH = 16;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);
	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
	localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;
	localparam logic signed [56:0] HALF_Q30_S = 57'sd536870912;
	localparam logic [1:0] LAST_ROW = 2'd3;

	localparam logic [31:0] ATAN_TURN [ANG_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	typedef struct packed {
		logic signed [23:0] scale_x;
		logic signed [23:0] scale_y;
		logic signed [23:0] scale_z;
		logic [15:0] angle_x;
		logic [15:0] angle_y;
		logic [15:0] angle_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_t;

	typedef struct packed {
		logic [1:0] row_index;
		logic signed [31:0] col0;
		logic signed [31:0] col1;
		logic signed [31:0] col2;
		logic last_row;
	} out_t;

	typedef struct packed {
		logic signed [23:0] sx;
		logic signed [23:0] sy;
		logic signed [23:0] sz;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} side_t;

	typedef logic [3:0][2:0][31:0] mat_t;

	function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b + HALF_Q30;
		return p[61:30];
	endfunction

	function automatic logic [31:0] scale_elem(input logic signed [32:0] r,
			input logic signed [23:0] s);
		logic signed [56:0] p;
		logic signed [26:0] v;
		p = r * s + HALF_Q30_S;
		v = p[56:30];
		return 32'(v);
	endfunction

endpackage

// File: rtl/euler_srt_world_matrix_core.sv
// Euler scale-rotate-translate world matrix builder.
// Input channel: an item (scale, three binary angles, position) is taken on a
// clock edge with push high and full low. Output channel: while empty is low
// the oldest matrix row sits on result; pop takes it. Each item yields four
// rows, 0 to 3, and row 3 (the position) carries last_row.
// The first row of an item passes through three pipelined 30-step CORDIC
// units, three product stages, the matrix queue and the row hold register.
// Throughput: one row per cycle while pop is high and empty is low; the
// single result channel sets this rate. Items enter back to back until
// 16 items sit in the compute pipeline and the matrix queue together.
// When the receiver stalls, the current row holds and finished matrices
// collect in the queue; full rises once 16 are outstanding.
// Reset clears the pipeline valids, the queue and the row sequencer; the
// block is ready to take an item as soon as reset is released.
module euler_srt_world_matrix_core (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input esrt_pkg::in_t item,
	output logic empty,
	input logic pop,
	output esrt_pkg::out_t result
);
	import esrt_pkg::*;

	logic wr_valid, rd_valid, deq;
	mat_t wr_data, rd_data;

	esrt_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.deq(deq), .wr_valid(wr_valid), .wr_data(wr_data)
	);

	esrt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(wr_valid), .wr_data(wr_data),
		.rd(deq), .rd_valid(rd_valid), .rd_data(rd_data)
	);

	esrt_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(rd_valid), .q_data(rd_data),
		.deq(deq), .empty(empty), .pop(pop), .result(result)
	);

endmodule

// File: rtl/esrt_cordic.sv
module esrt_cordic (
	input logic clk,
	input logic [15:0] angle,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);
	import esrt_pkg::*;

	logic signed [XW-1:0] x_s [ANG_STEPS+1];
	logic signed [XW-1:0] y_s [ANG_STEPS+1];
	logic signed [XW-1:0] z_s [ANG_STEPS+1];
	logic neg_s [ANG_STEPS+1];
	logic neg;
	logic [31:0] a_fold;

	assign neg = angle[15] ^ angle[14];
	assign a_fold = {angle[15] ^ neg, angle[14:0], 16'b0};

	always_ff @(posedge clk) begin
		x_s[0] <= CORDIC_GAIN;
		y_s[0] <= '0;
		z_s[0] <= XW'($signed(a_fold));
		neg_s[0] <= neg;
	end

	for (genvar i = 0; i < ANG_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (!z_s[i][XW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - $signed({2'b00, ATAN_TURN[i]});
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + $signed({2'b00, ATAN_TURN[i]});
			end
			neg_s[i+1] <= neg_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (neg_s[ANG_STEPS]) begin
			cos_val <= 32'(-x_s[ANG_STEPS]);
			sin_val <= 32'(-y_s[ANG_STEPS]);
		end else begin
			cos_val <= 32'(x_s[ANG_STEPS]);
			sin_val <= 32'(y_s[ANG_STEPS]);
		end
	end

endmodule

// File: rtl/esrt_front.sv
module esrt_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input esrt_pkg::in_t item,
	input logic deq,
	output logic wr_valid,
	output esrt_pkg::mat_t wr_data
);
	import esrt_pkg::*;

	logic [QCW-1:0] cnt_q;
	logic acc;
	logic signed [31:0] cx, sx, cy, sy, cz, sz;
	logic vld_s [CORDIC_LAT];
	side_t side_s [CORDIC_LAT];

	logic v_s1, v_s2;
	logic signed [31:0] czcy_s1, szsx_s1, szcx_s1, czsy_s1, szcy_s1;
	logic signed [31:0] czsx_s1, czcx_s1, szsy_s1, cxsy_s1, cxcy_s1;
	logic signed [31:0] sx_s1, sy_s1, cy_s1;
	side_t side_s1, side_s2;
	logic signed [32:0] rot_s2 [9];

	assign full = (cnt_q == QCW'(QDEPTH));
	assign acc = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({acc, deq})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	esrt_cordic u_cordic_x (.clk(clk), .angle(item.angle_x), .cos_val(cx), .sin_val(sx));
	esrt_cordic u_cordic_y (.clk(clk), .angle(item.angle_y), .cos_val(cy), .sin_val(sy));
	esrt_cordic u_cordic_z (.clk(clk), .angle(item.angle_z), .cos_val(cz), .sin_val(sz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CORDIC_LAT; k++) vld_s[k] <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			wr_valid <= 1'b0;
		end else begin
			vld_s[0] <= acc;
			for (int k = 1; k < CORDIC_LAT; k++) vld_s[k] <= vld_s[k-1];
			v_s1 <= vld_s[CORDIC_LAT-1];
			v_s2 <= v_s1;
			wr_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= '{item.scale_x, item.scale_y, item.scale_z,
			item.pos_x, item.pos_y, item.pos_z};
		for (int k = 1; k < CORDIC_LAT; k++) side_s[k] <= side_s[k-1];

		czcy_s1 <= mul30(cz, cy);
		szsx_s1 <= mul30(sz, sx);
		szcx_s1 <= mul30(sz, cx);
		czsy_s1 <= mul30(cz, sy);
		szcy_s1 <= mul30(sz, cy);
		czsx_s1 <= mul30(cz, sx);
		czcx_s1 <= mul30(cz, cx);
		szsy_s1 <= mul30(sz, sy);
		cxsy_s1 <= mul30(cx, sy);
		cxcy_s1 <= mul30(cx, cy);
		sx_s1 <= sx;
		sy_s1 <= sy;
		cy_s1 <= cy;
		side_s1 <= side_s[CORDIC_LAT-1];

		rot_s2[0] <= 33'(czcy_s1) + 33'(mul30(szsx_s1, sy_s1));
		rot_s2[1] <= 33'(szcx_s1);
		rot_s2[2] <= 33'(mul30(szsx_s1, cy_s1)) - 33'(czsy_s1);
		rot_s2[3] <= 33'(mul30(czsx_s1, sy_s1)) - 33'(szcy_s1);
		rot_s2[4] <= 33'(czcx_s1);
		rot_s2[5] <= 33'(szsy_s1) + 33'(mul30(czsx_s1, cy_s1));
		rot_s2[6] <= 33'(cxsy_s1);
		rot_s2[7] <= -33'(sx_s1);
		rot_s2[8] <= 33'(cxcy_s1);
		side_s2 <= side_s1;

		for (int k = 0; k < 3; k++) begin
			wr_data[0][k] <= scale_elem(rot_s2[k], side_s2.sx);
			wr_data[1][k] <= scale_elem(rot_s2[3+k], side_s2.sy);
			wr_data[2][k] <= scale_elem(rot_s2[6+k], side_s2.sz);
		end
		wr_data[3][0] <= side_s2.px;
		wr_data[3][1] <= side_s2.py;
		wr_data[3][2] <= side_s2.pz;
	end

endmodule

// File: rtl/esrt_queue.sv
module esrt_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	input esrt_pkg::mat_t wr_data,
	input logic rd,
	output logic rd_valid,
	output esrt_pkg::mat_t rd_data
);
	import esrt_pkg::*;

	mat_t mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] n_q;

	assign rd_valid = (n_q != '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q <= '0;
		end else begin
			if (wr_valid) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			case ({wr_valid, rd})
				2'b10: n_q <= n_q + 1'b1;
				2'b01: n_q <= n_q - 1'b1;
				default: n_q <= n_q;
			endcase
		end
	end

endmodule

// File: rtl/esrt_back.sv
module esrt_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input esrt_pkg::mat_t q_data,
	output logic deq,
	output logic empty,
	input logic pop,
	output esrt_pkg::out_t result
);
	import esrt_pkg::*;

	mat_t hold_q;
	logic busy_q;
	logic [1:0] row_q;
	logic done;

	assign done = pop && busy_q && (row_q == LAST_ROW);
	assign deq = q_valid && (!busy_q || done);
	assign empty = !busy_q;

	assign result.row_index = row_q;
	assign result.col0 = hold_q[row_q][0];
	assign result.col1 = hold_q[row_q][1];
	assign result.col2 = hold_q[row_q][2];
	assign result.last_row = (row_q == LAST_ROW);

	always_ff @(posedge clk) begin
		if (deq) hold_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q <= '0;
		end else if (deq) begin
			busy_q <= 1'b1;
			row_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (pop && busy_q) begin
			row_q <= row_q + 1'b1;
		end
	end

endmodule
